// ===== rtl/core/cube_map_face_select_assert.svh =====
// Assertion macros used by the checker file.
`ifndef CUBE_MAP_FACE_SELECT_ASSERT_SVH
`define CUBE_MAP_FACE_SELECT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CMFS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cmfs: assertion failed");

// Next-cycle implication, disabled during reset.
`define CMFS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cmfs: assertion failed");

// Checks the cycle after reset is sampled low.
`define CMFS_ASSERT_RST(label, clk, rstn, cons) \
    label: assert property (@(posedge clk) !(rstn) |=> (cons)) \
        else $error("cmfs: reset check failed");

`endif

// ===== rtl/core/cmfs_pkg.sv =====
package cmfs_pkg;

    localparam int COMPONENT_BITS_DEF   = 16;
    localparam int UV_FRACTION_BITS_DEF = 16;

    localparam int FACE_W = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [FACE_W-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

endpackage

// ===== rtl/core/cube_map_face_select.sv =====
// Throughput: one word per cycle unless m_axis_tready holds it back; a stalled m_axis side holds
// the whole divider pipeline, and the 4-entry queue takes words from the front end until it is full.
// The datapath is a two-stage classifier, a 4-entry queue and a divider pipeline of UV_FRACTION_BITS + 2
// stages, one restoring step per stage, followed by the output register.
// Reset (aresetn low, synchronous) clears all valid flags and the queue; data is not reset.
module cube_map_face_select #(
    parameter int COMPONENT_BITS   = cmfs_pkg::COMPONENT_BITS_DEF,
    parameter int UV_FRACTION_BITS = cmfs_pkg::UV_FRACTION_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // dir_x, dir_y, dir_z
    input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // face, coord_u, coord_v
    output logic [((cmfs_pkg::FACE_W+2*UV_FRACTION_BITS+2+7)/8)*8-1:0] m_axis_tdata
);
    import cmfs_pkg::*;

    localparam int QW = FACE_W + 1 + 3 * (COMPONENT_BITS + 1);

    logic          push_valid, q_full;
    logic          q_pop, q_valid;
    logic [QW-1:0] push_data, q_data;

    cmfs_front #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .push_valid   (push_valid),
        .push_data    (push_data),
        .q_full       (q_full)
    );

    cmfs_queue #(
        .W(QW)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_data(push_data),
        .full     (q_full),
        .pop      (q_pop),
        .pop_valid(q_valid),
        .pop_data (q_data)
    );

    cmfs_back #(
        .COMPONENT_BITS  (COMPONENT_BITS),
        .UV_FRACTION_BITS(UV_FRACTION_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

endmodule

// ===== rtl/core/cmfs_front.sv =====
module cmfs_front #(
    parameter int COMPONENT_BITS = cmfs_pkg::COMPONENT_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // dir_x, dir_y, dir_z
    input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                                 push_valid,
    // face, zero, den, au, av
    output logic [cmfs_pkg::FACE_W+1+3*(COMPONENT_BITS+1)-1:0] push_data,
    input  logic                                 q_full
);
    import cmfs_pkg::*;

    localparam int C = COMPONENT_BITS;

    logic              f1_valid_reg, f1_valid_next;
    logic              f2_valid_reg, f2_valid_next;
    logic              f2_take;

    logic signed [C:0] xe, ye, ze;
    logic signed [C:0] xv_reg, yv_reg, zv_reg;
    logic signed [C:0] xn_reg, yn_reg, zn_reg;
    logic signed [C:0] xn_next, yn_next, zn_next;
    logic [C-1:0]      ax_reg, ay_reg, az_reg;
    logic [C-1:0]      ax_next, ay_next, az_next;

    face_t             face_sel;
    logic [C-1:0]      m_sel;
    logic signed [C:0] qu_sel, qv_sel;
    logic [C+1:0]      au_sum, av_sum;
    logic              zero_sel;

    logic [FACE_W-1:0] face_reg;
    logic              zero_reg;
    logic [C:0]        den_reg, au_reg, av_reg;

    assign xe = (C+1)'($signed(s_axis_tdata[0 +: C]));
    assign ye = (C+1)'($signed(s_axis_tdata[C +: C]));
    assign ze = (C+1)'($signed(s_axis_tdata[2*C +: C]));

    assign f2_take       = !f2_valid_reg || !q_full;
    assign s_axis_tready = !f1_valid_reg || f2_take;
    assign push_valid    = f2_valid_reg;
    assign push_data     = {av_reg, au_reg, den_reg, zero_reg, face_reg};

    // stage 1: negate and take magnitudes
    always_comb begin
        xn_next = -xe;
        yn_next = -ye;
        zn_next = -ze;
        ax_next = xe[C] ? xn_next[C-1:0] : xe[C-1:0];
        ay_next = ye[C] ? yn_next[C-1:0] : ye[C-1:0];
        az_next = ze[C] ? zn_next[C-1:0] : ze[C-1:0];
    end

    // stage 2: major axis, face and numerators
    always_comb begin
        zero_sel = (ax_reg == '0) && (ay_reg == '0) && (az_reg == '0);
        if (ax_reg >= ay_reg && ax_reg >= az_reg) begin
            m_sel = ax_reg;
            qv_sel = yn_reg;
            if (!xv_reg[C]) begin
                face_sel = FACE_POS_X;
                qu_sel   = zn_reg;
            end else begin
                face_sel = FACE_NEG_X;
                qu_sel   = zv_reg;
            end
        end else if (ay_reg >= az_reg) begin
            m_sel  = ay_reg;
            qu_sel = xv_reg;
            if (!yv_reg[C]) begin
                face_sel = FACE_POS_Y;
                qv_sel   = zv_reg;
            end else begin
                face_sel = FACE_NEG_Y;
                qv_sel   = zn_reg;
            end
        end else begin
            m_sel  = az_reg;
            qv_sel = yn_reg;
            if (!zv_reg[C]) begin
                face_sel = FACE_POS_Z;
                qu_sel   = xv_reg;
            end else begin
                face_sel = FACE_NEG_Z;
                qu_sel   = xn_reg;
            end
        end
        if (zero_sel) begin
            face_sel = FACE_POS_Z;
        end
        au_sum = (C+2)'(qu_sel) + {2'b00, m_sel};
        av_sum = (C+2)'(qv_sel) + {2'b00, m_sel};
    end

    always_comb begin
        f1_valid_next = s_axis_tready ? s_axis_tvalid : f1_valid_reg;
        f2_valid_next = f2_take ? f1_valid_reg : f2_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg <= f1_valid_next;
            f2_valid_reg <= f2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready) begin
            xv_reg <= xe;
            yv_reg <= ye;
            zv_reg <= ze;
            xn_reg <= xn_next;
            yn_reg <= yn_next;
            zn_reg <= zn_next;
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            az_reg <= az_next;
        end
        if (f2_take) begin
            face_reg <= face_sel;
            zero_reg <= zero_sel;
            den_reg  <= {m_sel, 1'b0};
            au_reg   <= au_sum[C:0];
            av_reg   <= av_sum[C:0];
        end
    end

endmodule

// ===== rtl/core/cmfs_queue.sv =====
module cmfs_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         pop_valid,
    output logic [W-1:0] pop_data
);
    import cmfs_pkg::*;

    logic [W-1:0]        mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                wr_en, rd_en;

    assign full      = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(wr_en) - (QUEUE_AW+1)'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/cmfs_back.sv =====
module cmfs_back #(
    parameter int COMPONENT_BITS   = cmfs_pkg::COMPONENT_BITS_DEF,
    parameter int UV_FRACTION_BITS = cmfs_pkg::UV_FRACTION_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    // face, zero, den, au, av
    input  logic [cmfs_pkg::FACE_W+1+3*(COMPONENT_BITS+1)-1:0] q_data,
    output logic q_pop,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // face, coord_u, coord_v
    output logic [((cmfs_pkg::FACE_W+2*UV_FRACTION_BITS+2+7)/8)*8-1:0] m_axis_tdata
);
    import cmfs_pkg::*;

    localparam int C  = COMPONENT_BITS;
    localparam int F  = UV_FRACTION_BITS;
    localparam int NS = F + 2;
    localparam int OW = ((FACE_W + 2*F + 2 + 7) / 8) * 8;
    localparam logic [F:0] COORD_HALF = (F+1)'(1) << (F - 1);

    logic              en;
    logic [FACE_W-1:0] in_face;
    logic              in_zero;
    logic [C:0]        in_den, in_au, in_av;

    logic [NS-1:0]     vld_reg, vld_next;
    logic [FACE_W-1:0] face_reg [NS];
    logic [FACE_W-1:0] face_next [NS];
    logic [NS-1:0]     zero_reg, zero_next;
    logic [C:0]        den_reg [NS];
    logic [C:0]        den_src [NS];
    logic [C:0]        rem_u_reg [NS];
    logic [C:0]        rem_v_reg [NS];
    logic [C:0]        rem_u_next [NS];
    logic [C:0]        rem_v_next [NS];
    logic [C:0]        trial_u [NS];
    logic [C:0]        trial_v [NS];
    logic [F+1:0]      quo_u_reg [NS];
    logic [F+1:0]      quo_v_reg [NS];
    logic [F+1:0]      quo_u_src [NS];
    logic [F+1:0]      quo_v_src [NS];
    logic [F+1:0]      quo_u_next [NS];
    logic [F+1:0]      quo_v_next [NS];
    logic [NS-1:0]     bit_u, bit_v;

    logic              out_valid_reg;
    logic [FACE_W-1:0] out_face_reg;
    logic [F:0]        out_u_reg, out_v_reg, out_u_next, out_v_next;
    logic [F+2:0]      sum_u, sum_v;

    assign in_face = q_data[0 +: FACE_W];
    assign in_zero = q_data[FACE_W];
    assign in_den  = q_data[FACE_W+1 +: C+1];
    assign in_au   = q_data[FACE_W+C+2 +: C+1];
    assign in_av   = q_data[FACE_W+2*C+3 +: C+1];

    assign en            = !out_valid_reg || m_axis_tready;
    assign q_pop         = en && q_valid;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OW'({out_v_reg, out_u_reg, out_face_reg});

    // one restoring step per stage, both coordinates side by side
    always_comb begin
        den_src[0]   = in_den;
        trial_u[0]   = in_au;
        trial_v[0]   = in_av;
        quo_u_src[0] = '0;
        quo_v_src[0] = '0;
        face_next[0] = in_face;
        zero_next[0] = in_zero;
        vld_next[0]  = q_valid;
        for (int k = 1; k < NS; k++) begin
            den_src[k]   = den_reg[k-1];
            trial_u[k]   = {rem_u_reg[k-1][C-1:0], 1'b0};
            trial_v[k]   = {rem_v_reg[k-1][C-1:0], 1'b0};
            quo_u_src[k] = quo_u_reg[k-1];
            quo_v_src[k] = quo_v_reg[k-1];
            face_next[k] = face_reg[k-1];
            zero_next[k] = zero_reg[k-1];
            vld_next[k]  = vld_reg[k-1];
        end
        for (int k = 0; k < NS; k++) begin
            bit_u[k]      = trial_u[k] >= den_src[k];
            bit_v[k]      = trial_v[k] >= den_src[k];
            rem_u_next[k] = bit_u[k] ? trial_u[k] - den_src[k] : trial_u[k];
            rem_v_next[k] = bit_v[k] ? trial_v[k] - den_src[k] : trial_v[k];
            quo_u_next[k] = {quo_u_src[k][F:0], bit_u[k]};
            quo_v_next[k] = {quo_v_src[k][F:0], bit_v[k]};
        end
    end

    // quotient carries one extra bit; halve it rounding up (a zero vector gives COORD_HALF)
    always_comb begin
        sum_u = {1'b0, quo_u_reg[NS-1]} + (F+3)'(1);
        sum_v = {1'b0, quo_v_reg[NS-1]} + (F+3)'(1);
        out_u_next = zero_reg[NS-1] ? COORD_HALF : sum_u[F+1:1];
        out_v_next = zero_reg[NS-1] ? COORD_HALF : sum_v[F+1:1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg       <= vld_next;
            out_valid_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            face_reg     <= face_next;
            zero_reg     <= zero_next;
            den_reg      <= den_src;
            rem_u_reg    <= rem_u_next;
            rem_v_reg    <= rem_v_next;
            quo_u_reg    <= quo_u_next;
            quo_v_reg    <= quo_v_next;
            out_face_reg <= face_reg[NS-1];
            out_u_reg    <= out_u_next;
            out_v_reg    <= out_v_next;
        end
    end

endmodule

// ===== rtl/core/cmfs_checker.sv =====
`include "cube_map_face_select_assert.svh"

module cmfs_checker #(
    parameter int UV_FRACTION_BITS = cmfs_pkg::UV_FRACTION_BITS_DEF
) (
    input logic aclk,
    input logic aresetn,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((cmfs_pkg::FACE_W+2*UV_FRACTION_BITS+2+7)/8)*8-1:0] m_axis_tdata
);
    import cmfs_pkg::*;

    localparam int F = UV_FRACTION_BITS;
    localparam logic [F:0] COORD_ONE = {1'b1, {F{1'b0}}};

    logic [FACE_W-1:0] face_w;
    logic [F:0]        coord_u_w, coord_v_w;
    logic              stall_w, coord_ok_w;

    assign face_w     = m_axis_tdata[0 +: FACE_W];
    assign coord_u_w  = m_axis_tdata[FACE_W +: F+1];
    assign coord_v_w  = m_axis_tdata[FACE_W+F+1 +: F+1];
    assign stall_w    = m_axis_tvalid && !m_axis_tready;
    assign coord_ok_w = (coord_u_w <= COORD_ONE) && (coord_v_w <= COORD_ONE);

    `CMFS_ASSERT_RST(a_reset_clears_out, aclk, aresetn, !m_axis_tvalid)
    `CMFS_ASSERT_NXT(a_out_holds, aclk, aresetn, stall_w, m_axis_tvalid && $stable(m_axis_tdata))
    `CMFS_ASSERT_IMP(a_coord_range, aclk, aresetn, m_axis_tvalid, coord_ok_w)
    `CMFS_ASSERT_IMP(a_face_range, aclk, aresetn, m_axis_tvalid, face_w <= FACE_NEG_Z)

endmodule

bind cube_map_face_select cmfs_checker #(
    .UV_FRACTION_BITS(UV_FRACTION_BITS)
) u_cmfs_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import cmfs_pkg::*;

    localparam int CB = 16;
    localparam int FB = 16;
    localparam int SW = ((3*CB+7)/8)*8;
    localparam int MW = ((FACE_W+2*FB+2+7)/8)*8;
    localparam int LATENCY = FB + 5;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        face_t       face;
        logic [FB:0] u;
        logic [FB:0] v;
    } face_uv_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [SW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [MW-1:0] m_axis_tdata;

    face_uv_t expected_face_uv[$];
    int mismatches = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit idle_en = 1'b1;

    cube_map_face_select #(
        .COMPONENT_BITS(CB),
        .UV_FRACTION_BITS(FB)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // (q/m + 1)/2 with FB fraction bits, ties round up
    function automatic logic [FB:0] face_coord(longint q, longint m);
        longint num;
        num = ((q + m) <<< FB) + m;
        return (FB+1)'(num / (2 * m));
    endfunction

    function automatic face_uv_t predict_face_uv(logic signed [CB-1:0] x, y, z);
        longint sx, sy, sz, ax, ay, az, qu, qv, m;
        face_uv_t r;
        sx = x;
        sy = y;
        sz = z;
        ax = sx < 0 ? -sx : sx;
        ay = sy < 0 ? -sy : sy;
        az = sz < 0 ? -sz : sz;
        if (ax == 0 && ay == 0 && az == 0) begin
            r.face = FACE_POS_Z;
            r.u = (FB+1)'(1 << (FB - 1));
            r.v = (FB+1)'(1 << (FB - 1));
            return r;
        end
        if (ax >= ay && ax >= az) begin
            m = ax;
            r.face = sx >= 0 ? FACE_POS_X : FACE_NEG_X;
            qu = sx >= 0 ? -sz : sz;
            qv = -sy;
        end else if (ay >= az) begin
            m = ay;
            r.face = sy >= 0 ? FACE_POS_Y : FACE_NEG_Y;
            qu = sx;
            qv = sy >= 0 ? sz : -sz;
        end else begin
            m = az;
            r.face = sz >= 0 ? FACE_POS_Z : FACE_NEG_Z;
            qu = sz >= 0 ? sx : -sx;
            qv = -sy;
        end
        r.u = face_coord(qu, m);
        r.v = face_coord(qv, m);
        return r;
    endfunction

    // magnitude 32768 only exists as the negative extreme
    function automatic logic signed [CB-1:0] signed_comp(int mag, bit neg);
        int val;
        val = (neg || mag >= (1 << (CB - 1))) ? -mag : mag;
        return val[CB-1:0];
    endfunction

    task automatic send_dir(input logic signed [CB-1:0] x, y, z);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {z, y, x};
        do @(posedge aclk); while (!s_axis_tready);
        expected_face_uv = {expected_face_uv, predict_face_uv(x, y, z)};
    endtask

    task automatic test_zero_and_extremes();
        send_dir(16'sd0, 16'sd0, 16'sd0);
        send_dir(-16'sd32768, 16'sd0, 16'sd0);
        send_dir(16'sd0, -16'sd32768, 16'sd0);
        send_dir(16'sd0, 16'sd0, -16'sd32768);
        send_dir(-16'sd32768, -16'sd32768, -16'sd32768);
        send_dir(-16'sd32768, 16'sd32767, -16'sd32767);
        send_dir(16'sd32767, -16'sd32767, 16'sd32767);
        send_dir(16'sd1, 16'sd0, 16'sd0);
    endtask

    task automatic test_each_face();
        send_dir(16'sd100, 16'sd30, -16'sd70);
        send_dir(-16'sd100, -16'sd30, 16'sd70);
        send_dir(16'sd25, 16'sd900, -16'sd400);
        send_dir(-16'sd25, -16'sd900, 16'sd400);
        send_dir(16'sd3, -16'sd2, 16'sd7);
        send_dir(-16'sd3, 16'sd2, -16'sd7);
    endtask

    task automatic test_axis_ties();
        send_dir(16'sd5, 16'sd5, 16'sd5);
        send_dir(-16'sd5, 16'sd5, -16'sd5);
        send_dir(16'sd2, -16'sd9, 16'sd9);
        send_dir(16'sd0, 16'sd9, -16'sd9);
        send_dir(-16'sd7, 16'sd7, 16'sd1);
        send_dir(16'sd3, 16'sd1, -16'sd3);
        send_dir(-16'sd32768, 16'sd0, -16'sd32768);
        send_dir(16'sd0, -16'sd32768, -16'sd32768);
    endtask

    task automatic test_random_mix(input int n);
        logic signed [CB-1:0] c[3];
        int kind, mag, lead;
        bit neg;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 9);
            mag = $urandom_range(0, 1 << (CB - 1));
            lead = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++) begin
                neg = 1'($urandom_range(0, 1));
                case (kind)
                    5: c[k] = signed_comp($urandom_range(0, 4), neg);
                    6: c[k] = signed_comp(mag, neg);
                    7: c[k] = (k == lead) ? signed_comp($urandom_range(0, mag), neg)
                                          : signed_comp(mag, neg);
                    8: begin
                        case ($urandom_range(0, 5))
                            0: c[k] = -16'sd32768;
                            1: c[k] = -16'sd32767;
                            2: c[k] = 16'sd32767;
                            3: c[k] = -16'sd1;
                            4: c[k] = 16'sd1;
                            default: c[k] = 16'sd0;
                        endcase
                    end
                    9: c[k] = (k == lead) ? signed_comp(mag, neg)
                                          : signed_comp($urandom_range(0, mag), neg);
                    default: c[k] = CB'($urandom);
                endcase
            end
            send_dir(c[0], c[1], c[2]);
        end
    endtask

    task automatic test_steady_stream(input int n);
        idle_en = 1'b0;
        test_random_mix(n);
    endtask

    always @(posedge aclk) begin
        int nxt;
        face_uv_t exp_r;
        face_uv_t got;
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.face = face_t'(m_axis_tdata[FACE_W-1:0]);
            got.u = m_axis_tdata[FACE_W +: FB+1];
            got.v = m_axis_tdata[FACE_W+FB+1 +: FB+1];
            if (expected_face_uv.size() == 0) begin
                $display("%0t: unexpected word face=%0d u=%0d v=%0d", $time,
                         got.face, got.u, got.v);
                mismatches++;
            end else begin
                exp_r = expected_face_uv.pop_front();
                if (got.face !== exp_r.face) begin
                    $display("%0t: face expected %0d actual %0d", $time, exp_r.face, got.face);
                    mismatches++;
                end
                if (got.u !== exp_r.u) begin
                    $display("%0t: coord_u expected %0d actual %0d", $time, exp_r.u, got.u);
                    mismatches++;
                end
                if (got.v !== exp_r.v) begin
                    $display("%0t: coord_v expected %0d actual %0d", $time, exp_r.v, got.v);
                    mismatches++;
                end
            end
        end
        // downstream backpressure in bursts
        nxt = 1;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            nxt = 0;
        end else if (idle_en && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 6);
            nxt = 0;
        end
        m_axis_tready <= nxt[0];
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_zero_and_extremes();
        test_each_face();
        test_axis_ties();
        test_random_mix(1050);
        test_steady_stream(200);
        s_axis_tvalid <= 1'b0;
        while (expected_face_uv.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cmfs_pkg.sv
rtl/core/cmfs_front.sv
rtl/core/cmfs_queue.sv
rtl/core/cmfs_back.sv
rtl/core/cube_map_face_select.sv
rtl/core/cmfs_checker.sv
dv/tb.sv
